>>> rtl/core/lfsa_pkg.sv
// Shared types and constants for the lowest-free slot allocator.
package lfsa_pkg;

  localparam int SLOTS       = 256;
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int CNT_W       = SLOT_W + 1;
  localparam int CHUNK       = 8;
  localparam int CHUNK_W     = $clog2(CHUNK);
  localparam int CHUNKS      = SLOTS / CHUNK;
  localparam int CHUNK_IDX_W = $clog2(CHUNKS);
  localparam int MARGIN_W    = 8;
  localparam int RAND_W      = 16;
  localparam int DIV_CNT_W   = $clog2(RAND_W);
  localparam int ACTION_W    = 2;
  localparam int STATUS_W    = 2;

  localparam logic [MARGIN_W-1:0] MARGIN_RESET = MARGIN_W'(8);
  localparam logic [SLOTS-1:0]    OCC_RESET    = {{(SLOTS-1){1'b0}}, 1'b1};

  typedef enum logic [ACTION_W-1:0] {
    ACT_ALLOC = 2'd0,
    ACT_FREE  = 2'd1,
    ACT_PICK  = 2'd2
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_NONE = 2'd2,
    ST_FAIL = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CH_HOLD,
    CH_HINT,
    CH_ZERO,
    CH_INC
  } chunk_op_t;

  typedef enum logic [1:0] {
    MODE_HI,
    MODE_LO,
    MODE_PICK
  } scan_mode_t;

  typedef enum logic [1:0] {
    SEL_ZERO,
    SEL_GIVEN,
    SEL_FOUND,
    SEL_REQ
  } slot_sel_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN_HI,
    S_SCAN_LO,
    S_DIV,
    S_PICK_LOAD,
    S_PICK
  } state_t;

  typedef struct packed {
    logic       load;
    chunk_op_t  chunk_op;
    scan_mode_t mode;
    logic       alloc_commit;
    logic       hint_load;
    logic       free_commit;
    logic       div_init;
    logic       div_step;
    logic       k_load;
    logic       k_sub;
    logic       finish;
    status_t    fin_status;
    slot_sel_t  fin_sel;
  } lfsa_cmd_t;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic                full;
    logic                free_bad;
    logic                pick_none;
    logic                create_ok;
    logic                hit;
    logic                last_chunk;
    logic                hint_chunk;
    logic                div_last;
  } lfsa_stat_t;

endpackage

>>> rtl/core/lfsa_ctrl.sv
// Request sequencer for the slot allocator: decode, scan, divide and pick phases.
module lfsa_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  lfsa_pkg::lfsa_stat_t stat,
  output lfsa_pkg::lfsa_cmd_t  cmd
);
  import lfsa_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) state_next = S_DECODE;
      end
      S_DECODE: begin
        case (stat.action)
          ACT_ALLOC: state_next = stat.full ? S_IDLE : S_SCAN_HI;
          ACT_PICK:  state_next = stat.pick_none ? S_IDLE : S_DIV;
          default:   state_next = S_IDLE;
        endcase
      end
      S_SCAN_HI: begin
        if (stat.hit) state_next = S_IDLE;
        else if (stat.last_chunk) state_next = S_SCAN_LO;
      end
      S_SCAN_LO: begin
        if (stat.hit || stat.hint_chunk) state_next = S_IDLE;
      end
      S_DIV: begin
        if (stat.div_last) state_next = S_PICK_LOAD;
      end
      S_PICK_LOAD: state_next = S_PICK;
      S_PICK: begin
        if (stat.hit || stat.last_chunk) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd            = '0;
    cmd.chunk_op   = CH_HOLD;
    cmd.mode       = MODE_HI;
    cmd.fin_status = ST_NONE;
    cmd.fin_sel    = SEL_ZERO;
    case (state)
      S_IDLE: begin
        cmd.load = start;
      end
      S_DECODE: begin
        case (stat.action)
          ACT_ALLOC: begin
            if (stat.full) begin
              cmd.finish     = 1'b1;
              cmd.fin_status = ST_FULL;
            end else begin
              cmd.chunk_op = CH_HINT;
            end
          end
          ACT_FREE: begin
            cmd.finish = 1'b1;
            if (!stat.free_bad) begin
              cmd.free_commit = 1'b1;
              cmd.fin_status  = ST_OK;
              cmd.fin_sel     = SEL_REQ;
            end
          end
          ACT_PICK: begin
            if (stat.pick_none) cmd.finish = 1'b1;
            else cmd.div_init = 1'b1;
          end
          default: cmd.finish = 1'b1;
        endcase
      end
      S_SCAN_HI, S_SCAN_LO: begin
        cmd.mode = (state == S_SCAN_HI) ? MODE_HI : MODE_LO;
        // nothing else free: hint stays on the slot handed out
        if (stat.hit || (state == S_SCAN_LO && stat.hint_chunk)) begin
          cmd.alloc_commit = 1'b1;
          cmd.hint_load    = stat.hit;
          cmd.finish       = 1'b1;
          cmd.fin_status   = stat.create_ok ? ST_OK : ST_FAIL;
          cmd.fin_sel      = stat.create_ok ? SEL_GIVEN : SEL_ZERO;
        end else if (state == S_SCAN_HI && stat.last_chunk) begin
          cmd.chunk_op = CH_ZERO;
        end else begin
          cmd.chunk_op = CH_INC;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
      end
      S_PICK_LOAD: begin
        cmd.k_load   = 1'b1;
        cmd.chunk_op = CH_ZERO;
      end
      S_PICK: begin
        cmd.mode = MODE_PICK;
        if (stat.hit) begin
          cmd.finish     = 1'b1;
          cmd.fin_status = ST_OK;
          cmd.fin_sel    = SEL_FOUND;
        end else if (stat.last_chunk) begin
          cmd.finish = 1'b1;
        end else begin
          cmd.chunk_op = CH_INC;
          cmd.k_sub    = 1'b1;
        end
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/core/lfsa_dp.sv
// Datapath: occupancy bits, hint, live count, chunk scanner, modulo unit, result registers.
module lfsa_dp (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [lfsa_pkg::MARGIN_W-1:0]  cfg_data,
  input  logic [lfsa_pkg::ACTION_W-1:0]  action,
  input  logic [lfsa_pkg::SLOT_W-1:0]    slot_id,
  input  logic                           create_ok,
  input  logic [lfsa_pkg::RAND_W-1:0]    rand_value,
  input  lfsa_pkg::lfsa_cmd_t            cmd,
  output lfsa_pkg::lfsa_stat_t           stat,
  output logic                           done,
  output logic [lfsa_pkg::STATUS_W-1:0]  status,
  output logic [lfsa_pkg::SLOT_W-1:0]    slot_out
);
  import lfsa_pkg::*;

  // held request
  logic [ACTION_W-1:0]    act_q;
  logic [SLOT_W-1:0]      slot_q;
  logic                   ok_q;

  logic [MARGIN_W-1:0]    margin;
  logic [SLOTS-1:0]       occ;
  logic [SLOT_W-1:0]      hint;
  logic [CNT_W-1:0]       count;

  logic [CHUNK_IDX_W-1:0] chunk;
  logic [RAND_W-1:0]      rsh;
  logic [SLOT_W-1:0]      rem;
  logic [DIV_CNT_W-1:0]   div_cnt;
  logic [SLOT_W-1:0]      k;

  status_t                status_q;
  logic [SLOT_W-1:0]      slot_res;

  logic [CHUNK-1:0]       occ_chunk;
  logic [CHUNK-1:0]       scan_bits;
  logic [CHUNK_W-1:0]     sel_low;
  logic [CHUNK_W-1:0]     sel_kth;
  logic [CHUNK_W:0]       pop;
  logic [CHUNK_W:0]       run;
  logic [SLOT_W-1:0]      idx;
  logic [SLOT_W-1:0]      found;
  logic                   hit;
  logic [CNT_W:0]         need;
  logic [SLOT_W-1:0]      divisor;
  logic [SLOT_W:0]        trial;
  logic [SLOT_W:0]        trial_sub;

  assign occ_chunk = occ[{chunk, CHUNK_W'(0)} +: CHUNK];

  always_comb begin
    scan_bits = '0;
    sel_low   = '0;
    sel_kth   = '0;
    pop       = '0;
    run       = '0;
    idx       = '0;
    for (int j = 0; j < CHUNK; j++) begin
      idx = {chunk, CHUNK_W'(j)};
      case (cmd.mode)
        MODE_HI:   scan_bits[j] = !occ_chunk[j] && (idx != '0) && (idx > hint);
        MODE_LO:   scan_bits[j] = !occ_chunk[j] && (idx != '0) && (idx < hint);
        MODE_PICK: scan_bits[j] = occ_chunk[j] && (idx != '0);
        default:   scan_bits[j] = 1'b0;
      endcase
    end
    for (int j = CHUNK - 1; j >= 0; j--) begin
      if (scan_bits[j]) sel_low = CHUNK_W'(j);
    end
    // k-th set bit inside the chunk
    for (int j = 0; j < CHUNK; j++) begin
      if (scan_bits[j]) begin
        run = run + 1'b1;
        if ({{(SLOT_W-CHUNK_W-1){1'b0}}, run} == k) sel_kth = CHUNK_W'(j);
      end
    end
    pop = run;
  end

  always_comb begin
    if (cmd.mode == MODE_PICK) begin
      hit   = ({{(SLOT_W-CHUNK_W-1){1'b0}}, pop} >= k);
      found = {chunk, sel_kth};
    end else begin
      hit   = |scan_bits;
      found = {chunk, sel_low};
    end
  end

  assign need      = {1'b0, count} + {{(CNT_W+1-MARGIN_W){1'b0}}, margin};
  assign divisor   = SLOT_W'(count - CNT_W'(1));
  assign trial     = {rem, rsh[RAND_W-1]};
  assign trial_sub = trial - {1'b0, divisor};

  always_comb begin
    stat            = '0;
    stat.action     = act_q;
    stat.full       = (need > (CNT_W+1)'(SLOTS)) || (hint == '0) || occ[hint];
    stat.free_bad   = (slot_q == '0) || ({1'b0, slot_q} >= CNT_W'(SLOTS)) || !occ[slot_q];
    stat.pick_none  = (count <= CNT_W'(1));
    stat.create_ok  = ok_q;
    stat.hit        = hit;
    stat.last_chunk = (chunk == CHUNK_IDX_W'(CHUNKS - 1));
    stat.hint_chunk = (chunk == hint[SLOT_W-1:CHUNK_W]);
    stat.div_last   = (div_cnt == DIV_CNT_W'(RAND_W - 1));
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      margin <= MARGIN_RESET;
      occ    <= OCC_RESET;
      hint   <= SLOT_W'(1);
      count  <= CNT_W'(1);
      done   <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cfg_we) margin <= cfg_data;
      if (cmd.alloc_commit) begin
        if (cmd.hint_load) hint <= found;
        if (ok_q) begin
          occ[hint] <= 1'b1;
          count     <= count + CNT_W'(1);
        end
      end
      if (cmd.free_commit) begin
        occ[slot_q] <= 1'b0;
        if (count != '0) count <= count - CNT_W'(1);
        if (slot_q < hint) hint <= slot_q;
      end
    end
  end

  // request payload, scan position, modulo unit, result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_q  <= action;
      slot_q <= slot_id;
      ok_q   <= create_ok;
      rsh    <= rand_value;
    end
    case (cmd.chunk_op)
      CH_HINT: chunk <= hint[SLOT_W-1:CHUNK_W];
      CH_ZERO: chunk <= '0;
      CH_INC:  chunk <= chunk + CHUNK_IDX_W'(1);
      default: ;
    endcase
    if (cmd.div_init) begin
      rem     <= '0;
      div_cnt <= '0;
    end
    if (cmd.div_step) begin
      rem     <= (trial >= {1'b0, divisor}) ? trial_sub[SLOT_W-1:0] : trial[SLOT_W-1:0];
      rsh     <= {rsh[RAND_W-2:0], 1'b0};
      div_cnt <= div_cnt + DIV_CNT_W'(1);
    end
    if (cmd.k_load) k <= rem + SLOT_W'(1);
    if (cmd.k_sub)  k <= k - {{(SLOT_W-CHUNK_W-1){1'b0}}, pop};
    if (cmd.finish) begin
      status_q <= cmd.fin_status;
      case (cmd.fin_sel)
        SEL_GIVEN: slot_res <= hint;
        SEL_FOUND: slot_res <= found;
        SEL_REQ:   slot_res <= slot_q;
        default:   slot_res <= '0;
      endcase
    end
  end

  assign status   = status_q;
  assign slot_out = slot_res;

endmodule

>>> rtl/core/lowest_free_slot_allocator_top.sv
// Lowest-free slot allocator: sequencer plus datapath.
// A request is taken when start is high and busy is low; its result shows for one
// cycle with done. Free and all refusals finish in the decode state. Allocate runs
// the 8-slot-per-cycle occupancy scan (up to 33 chunk checks: above the hint, then
// wrapped from the bottom back to the hint's chunk).
// Pick: a bit-serial modulo, then a scan from slot 0.
// One request at a time: a new one is taken only once busy drops; done cannot be held off.
// Synchronous reset: slot 0 held, hint 1, count 1, margin 8.
module lowest_free_slot_allocator_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [lfsa_pkg::ACTION_W-1:0] action,
  input  logic [lfsa_pkg::SLOT_W-1:0]   slot_id,
  input  logic                          create_ok,
  input  logic [lfsa_pkg::RAND_W-1:0]   rand_value,
  output logic                          done,
  output logic [lfsa_pkg::STATUS_W-1:0] status,
  output logic [lfsa_pkg::SLOT_W-1:0]   slot_out,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [lfsa_pkg::MARGIN_W-1:0] reserve_margin
);
  import lfsa_pkg::*;

  lfsa_cmd_t  cmd;
  lfsa_stat_t stat;

  assign cfg_ready = 1'b1;

  lfsa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  lfsa_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_data   (reserve_margin),
    .action     (action),
    .slot_id    (slot_id),
    .create_ok  (create_ok),
    .rand_value (rand_value),
    .cmd        (cmd),
    .stat       (stat),
    .done       (done),
    .status     (status),
    .slot_out   (slot_out)
  );

endmodule

>>> rtl/core/lfsa_chk.sv
// Port-level checks for the slot allocator, bound to the top level.
module lfsa_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic                          done,
  input logic [lfsa_pkg::STATUS_W-1:0] status,
  input logic [lfsa_pkg::SLOT_W-1:0]   slot_out
);
  import lfsa_pkg::*;

  // a result always closes its request
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result shown while still busy");

  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> (busy && !done))
    else $error("accepted request did not go busy");

  // any refusal or failure reports slot zero
  assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (slot_out == '0))
    else $error("nonzero slot on a failed request");

  // slot 0 is never handed out, freed or picked
  assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_OK) |-> (slot_out != '0))
    else $error("slot zero returned with ok status");

endmodule

bind lowest_free_slot_allocator_top lfsa_chk u_lfsa_chk (
  .clk      (clk),
  .rst      (rst),
  .start    (start),
  .busy     (busy),
  .done     (done),
  .status   (status),
  .slot_out (slot_out)
);

>>> verif/lfsa_reply_checker.sv
// Reply checker for the slot allocator: tracks the slot table and compares every reply.
`timescale 1ns / 100ps
module lfsa_reply_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          busy,
  input  logic [lfsa_pkg::ACTION_W-1:0] action,
  input  logic [lfsa_pkg::SLOT_W-1:0]   slot_id,
  input  logic                          create_ok,
  input  logic [lfsa_pkg::RAND_W-1:0]   rand_value,
  input  logic                          done,
  input  logic [lfsa_pkg::STATUS_W-1:0] status,
  input  logic [lfsa_pkg::SLOT_W-1:0]   slot_out,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [lfsa_pkg::MARGIN_W-1:0] reserve_margin,
  output int                            errors,
  output int                            outstanding,
  output int                            n_ok,
  output int                            n_full,
  output int                            n_none,
  output int                            n_fail
);
  import lfsa_pkg::*;

  typedef struct {
    status_t           st;
    logic [SLOT_W-1:0] slot;
  } reply_t;

  reply_t            reply_q[$];
  reply_t            want;
  bit                occ[SLOTS];
  logic [SLOT_W-1:0] hint;
  int                live;
  int                margin;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: MISMATCH %s", $time, msg);
    errors++;
  endtask

  // next empty nonzero slot above 'from', wrapping; stays put if none
  function automatic logic [SLOT_W-1:0] next_empty(input logic [SLOT_W-1:0] from);
    logic [SLOT_W-1:0] i;
    logic [SLOT_W-1:0] hit;
    bit                found;
    int                n;
    i = from;
    hit = from;
    found = 0;
    for (n = 0; n < SLOTS; n++) begin
      i = i + 1'b1;
      if (!found && i != 0 && !occ[i]) begin
        found = 1;
        hit = i;
      end
    end
    return hit;
  endfunction

  function automatic reply_t slot_table_step(input logic [ACTION_W-1:0] act,
                                             input logic [SLOT_W-1:0] sid,
                                             input logic ok,
                                             input logic [RAND_W-1:0] rv);
    reply_t            r;
    logic [SLOT_W-1:0] given;
    int                k;
    int                i;
    r.st = ST_NONE;
    r.slot = '0;
    case (act)
      ACT_ALLOC: begin
        given = hint;
        if (live + margin > SLOTS || given == 0 || occ[given]) begin
          r.st = ST_FULL;
        end else begin
          hint = next_empty(given);
          if (!ok) begin
            r.st = ST_FAIL;
          end else begin
            occ[given] = 1;
            live++;
            r.st = ST_OK;
            r.slot = given;
          end
        end
      end
      ACT_FREE: begin
        if (sid != 0 && occ[sid]) begin
          occ[sid] = 0;
          if (live > 0) live--;
          if (sid < hint) hint = sid;
          r.st = ST_OK;
          r.slot = sid;
        end
      end
      ACT_PICK: begin
        if (live > 1) begin
          k = int'(rv) % (live - 1) + 1;
          for (i = 1; i < SLOTS; i++) begin
            if (occ[i] && k > 0) begin
              k--;
              if (k == 0) begin
                r.st = ST_OK;
                r.slot = SLOT_W'(i);
              end
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      foreach (occ[j]) occ[j] = 0;
      occ[0] = 1;
      hint = SLOT_W'(1);
      live = 1;
      margin = int'(MARGIN_RESET);
      reply_q.delete();
    end else begin
      if (done) begin
        if (reply_q.size() == 0) begin
          report_mismatch($sformatf("reply with nothing pending: status %0d slot %0d",
                                    status, slot_out));
        end else begin
          want = reply_q.pop_front();
          if (status !== want.st)
            report_mismatch($sformatf("status %0d, expected %0d", status, want.st));
          if (slot_out !== want.slot)
            report_mismatch($sformatf("slot_out %0d, expected %0d", slot_out, want.slot));
          case (want.st)
            ST_OK:   n_ok++;
            ST_FULL: n_full++;
            ST_NONE: n_none++;
            default: n_fail++;
          endcase
        end
      end
      if (cfg_valid && cfg_ready) margin = int'(reserve_margin);
      if (start && !busy)
        reply_q.push_back(slot_table_step(action, slot_id, create_ok, rand_value));
    end
    outstanding = reply_q.size();
  end

endmodule

>>> verif/tb_lowest_free_slot_allocator_top.sv
// Testbench top for the slot allocator: clock, reset, request stimulus and verdict.
`timescale 1ns / 100ps
module tb_lowest_free_slot_allocator_top;
  import lfsa_pkg::*;

  localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                start = 1'b0;
  logic                busy;
  logic [ACTION_W-1:0] action = '0;
  logic [SLOT_W-1:0]   slot_id = '0;
  logic                create_ok = 1'b0;
  logic [RAND_W-1:0]   rand_value = '0;
  logic                done;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot_out;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [MARGIN_W-1:0] reserve_margin = '0;

  int errors;
  int outstanding;
  int n_ok;
  int n_full;
  int n_none;
  int n_fail;
  int sent = 0;
  bit idle_on = 1'b1;

  always #4 clk = ~clk;

  lowest_free_slot_allocator_top u_top (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .action         (action),
    .slot_id        (slot_id),
    .create_ok      (create_ok),
    .rand_value     (rand_value),
    .done           (done),
    .status         (status),
    .slot_out       (slot_out),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .reserve_margin (reserve_margin)
  );

  lfsa_reply_checker u_check (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .action         (action),
    .slot_id        (slot_id),
    .create_ok      (create_ok),
    .rand_value     (rand_value),
    .done           (done),
    .status         (status),
    .slot_out       (slot_out),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .reserve_margin (reserve_margin),
    .errors         (errors),
    .outstanding    (outstanding),
    .n_ok           (n_ok),
    .n_full         (n_full),
    .n_none         (n_none),
    .n_fail         (n_fail)
  );

  // start stays high across back-to-back requests; it drops only for a gap or in wait_idle
  task automatic send_request(input logic [ACTION_W-1:0] act, input logic [SLOT_W-1:0] sid,
                              input logic ok, input logic [RAND_W-1:0] rv);
    int gap;
    if (idle_on && $urandom_range(0, 99) < 30) begin
      gap = $urandom_range(1, 16);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start      <= 1'b1;
    action     <= act;
    slot_id    <= sid;
    create_ok  <= ok;
    rand_value <= rv;
    do @(posedge clk); while (busy);
    sent++;
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_margin(input logic [MARGIN_W-1:0] m);
    reserve_margin <= m;
    cfg_valid      <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // weights in percent; what is left over goes to the unused action
  task automatic run_mix(input int n, input int w_alloc, input int w_free, input int w_pick,
                         input int ok_pct, input bit allow_idle);
    int                  i;
    int                  r;
    logic [ACTION_W-1:0] act;
    logic [SLOT_W-1:0]   sid;
    logic [RAND_W-1:0]   rv;
    logic                ok;
    for (i = 0; i < n; i++) begin
      if (i % 24 == 0) idle_on = allow_idle && ($urandom_range(0, 2) != 0);
      r = $urandom_range(0, 99);
      if (r < w_alloc) act = ACT_ALLOC;
      else if (r < w_alloc + w_free) act = ACT_FREE;
      else if (r < w_alloc + w_free + w_pick) act = ACT_PICK;
      else act = ACT_SPARE;
      r = $urandom_range(0, 99);
      // low slots are the busy ones, so most frees land on occupied entries
      if (r < 75) sid = SLOT_W'($urandom_range(1, 48));
      else if (r < 95) sid = SLOT_W'($urandom_range(0, 255));
      else sid = '0;
      ok = ($urandom_range(0, 99) < ok_pct);
      rv = RAND_W'($urandom_range(0, 65535));
      send_request(act, sid, ok, rv);
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // reset margin of 8
    send_request(ACT_PICK,  8'h00, 1'b1, 16'h0000);   // no workers yet
    send_request(ACT_FREE,  8'h00, 1'b1, 16'hFFFF);   // slot 0 is never freed
    send_request(ACT_FREE,  8'hFF, 1'b0, 16'h0000);   // empty slot
    send_request(ACT_SPARE, 8'hFF, 1'b1, 16'hFFFF);
    send_request(ACT_ALLOC, 8'h00, 1'b0, 16'h0000);   // creation fails, hint moves on
    send_request(ACT_ALLOC, 8'hFF, 1'b1, 16'h0000);
    send_request(ACT_ALLOC, 8'h55, 1'b1, 16'hAAAA);
    send_request(ACT_ALLOC, 8'hAA, 1'b1, 16'h5555);
    send_request(ACT_PICK,  8'h00, 1'b0, 16'h0000);
    send_request(ACT_PICK,  8'hFF, 1'b0, 16'hFFFF);
    send_request(ACT_PICK,  8'h55, 1'b1, 16'h5555);
    send_request(ACT_FREE,  8'h03, 1'b0, 16'hAAAA);
    send_request(ACT_FREE,  8'h03, 1'b1, 16'h0000);   // now empty
    send_request(ACT_ALLOC, 8'h00, 1'b1, 16'h0000);   // lowered hint reuses it
    send_request(ACT_ALLOC, 8'h00, 1'b1, 16'h0000);
    send_request(ACT_FREE,  8'hAA, 1'b1, 16'h0000);
    send_request(ACT_FREE,  8'h55, 1'b1, 16'h0000);
    send_request(ACT_FREE,  8'h01, 1'b1, 16'h0000);

    wait_idle();
    write_margin(8'hFF);
    send_request(ACT_ALLOC, 8'h00, 1'b1, 16'h0000);   // refused by the margin
    run_mix(30, 30, 50, 15, 90, 1'b1);

    wait_idle();
    write_margin(8'd250);
    run_mix(40, 45, 35, 15, 90, 1'b1);

    wait_idle();
    write_margin(8'd200);
    run_mix(60, 50, 30, 15, 90, 1'b1);

    // no margin: fill every slot, so the hint ends on an occupied slot
    wait_idle();
    write_margin(8'd0);
    run_mix(150, 95, 0, 5, 98, 1'b1);
    wait_idle();
    run_mix(150, 95, 0, 5, 98, 1'b1);
    run_mix(100, 25, 55, 15, 80, 1'b1);

    wait_idle();
    write_margin(MARGIN_W'($urandom_range(0, 255)));
    run_mix(60, 40, 35, 20, 85, 1'b1);

    wait_idle();
    write_margin(MARGIN_RESET);
    idle_on = 1'b0;
    run_mix(50, 40, 35, 20, 85, 1'b0);

    wait_idle();
    repeat (72) @(posedge clk);
    $display("%0d requests across seven margin settings, 0 and 255 included, table run full",
             sent);
    $display("replies: %0d ok, %0d full, %0d invalid or none, %0d creation failed",
             n_ok, n_full, n_none, n_fail);
    if (errors == 0 && outstanding == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Timeout: allocator stopped answering");
    $display("Test completed with failures");
    $finish;
  end

endmodule
